>>> hdl/flr_pkg.sv
package flr_pkg;

    // Fixed field widths of the request and result ports.
    localparam int KIND_W   = 2;
    localparam int POS_W    = 10;
    localparam int TAP_W    = 6;
    localparam int WEIGHT_W = 24;
    localparam int FIRST_W  = 10;
    localparam int COUNT_W  = 7;
    localparam int SAMPLE_W = 8;
    localparam int PIXEL_W  = 8;

    // Weights carry this many fraction bits.
    localparam int PRECISION = 22;
    localparam int PIXEL_MAX = 255;

    typedef enum logic [KIND_W-1:0] {
        KIND_WEIGHT  = 2'd0,
        KIND_BOUNDS  = 2'd1,
        KIND_SAMPLE  = 2'd2,
        KIND_COMPUTE = 2'd3
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load;
        logic issue;
        logic emit;
    } flr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic compute_req;
        logic issue_done;
        logic pipe_empty;
    } flr_sts_t;

endpackage

>>> hdl/flr_ctrl.sv
module flr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  flr_pkg::flr_sts_t sts,
    output flr_pkg::flr_cmd_t cmd,
    output logic              busy,
    output logic              done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BOUNDS,
        ST_MAC,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && sts.compute_req)
                begin
                    state_next = ST_BOUNDS;
                end
            end
            ST_BOUNDS:
            begin
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (sts.issue_done && sts.pipe_empty)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
            done_reg  <= (state_reg == ST_FINISH);
        end
    end

    always_comb
    begin
        cmd.accept = start && (state_reg == ST_IDLE);
        cmd.load   = (state_reg == ST_BOUNDS);
        cmd.issue  = (state_reg == ST_MAC);
        cmd.emit   = (state_reg == ST_FINISH);
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

>>> hdl/flr_datapath.sv
module flr_datapath #(
    parameter int LINE_MAX   = 1024,
    parameter int OUT_MAX    = 1024,
    parameter int KERNEL_MAX = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  flr_pkg::flr_cmd_t                   cmd,
    output flr_pkg::flr_sts_t                   sts,
    input  logic [flr_pkg::KIND_W-1:0]          kind,
    input  logic [flr_pkg::POS_W-1:0]           position,
    input  logic [flr_pkg::TAP_W-1:0]           tap,
    input  logic signed [flr_pkg::WEIGHT_W-1:0] weight,
    input  logic [flr_pkg::FIRST_W-1:0]         first_sample,
    input  logic [flr_pkg::COUNT_W-1:0]         tap_count,
    input  logic [flr_pkg::SAMPLE_W-1:0]        sample,
    output logic [flr_pkg::PIXEL_W-1:0]         pixel,
    output logic [flr_pkg::POS_W-1:0]           out_index
);

    localparam int LA     = $clog2(LINE_MAX);
    localparam int OA     = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int WDEPTH = OUT_MAX * KERNEL_MAX;
    localparam int WA     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int CW     = $clog2(KERNEL_MAX + 1);
    localparam int IDX_W  = $clog2((1 << flr_pkg::FIRST_W) + KERNEL_MAX);
    localparam int PROD_W = flr_pkg::SAMPLE_W + 1 + flr_pkg::WEIGHT_W;
    localparam int ACC_W  = PROD_W + 1 + $clog2(KERNEL_MAX);
    localparam int BND_W  = flr_pkg::FIRST_W + CW;
    localparam int PIX_LO = flr_pkg::PRECISION;
    localparam int PIX_HI = flr_pkg::PRECISION + flr_pkg::PIXEL_W;
    localparam logic signed [ACC_W-1:0] ACC_INIT = ACC_W'(1) << (flr_pkg::PRECISION - 1);

    logic [flr_pkg::SAMPLE_W-1:0]        line_mem [LINE_MAX];
    logic signed [flr_pkg::WEIGHT_W-1:0] weight_mem [WDEPTH];
    logic [BND_W-1:0]                    bounds_mem [OUT_MAX];

    logic                                line_we;
    logic                                weight_we;
    logic                                bounds_we;
    logic [CW-1:0]                       count_sat;
    logic [WA-1:0]                       weight_wr_addr;
    logic [WA-1:0]                       weight_rd_addr;
    logic [IDX_W-1:0]                    idx;
    logic                                issue_en;

    logic [flr_pkg::POS_W-1:0]           pos_reg;
    logic [BND_W-1:0]                    bounds_q_reg;
    logic [flr_pkg::FIRST_W-1:0]         base_reg;
    logic [CW-1:0]                       cnt_reg;
    logic [CW-1:0]                       tap_reg;
    logic                                s1_valid_reg;
    logic                                s1_inrange_reg;
    logic [flr_pkg::SAMPLE_W-1:0]        smp_q_reg;
    logic signed [flr_pkg::WEIGHT_W-1:0] wgt_q_reg;
    logic                                s2_valid_reg;
    logic signed [PROD_W-1:0]            prod_reg;
    logic signed [ACC_W-1:0]             acc_reg;
    logic [flr_pkg::PIXEL_W-1:0]         pixel_clip;
    logic [flr_pkg::PIXEL_W-1:0]         pixel_reg;
    logic [flr_pkg::POS_W-1:0]           index_reg;

    // Request decode for the table and line writes.
    always_comb
    begin
        line_we   = 1'b0;
        weight_we = 1'b0;
        bounds_we = 1'b0;
        unique case (kind)
            flr_pkg::KIND_WEIGHT:
            begin
                weight_we = cmd.accept && (32'(position) < OUT_MAX) && (32'(tap) < KERNEL_MAX);
            end
            flr_pkg::KIND_BOUNDS:
            begin
                bounds_we = cmd.accept && (32'(position) < OUT_MAX);
            end
            flr_pkg::KIND_SAMPLE:
            begin
                line_we = cmd.accept && (32'(position) < LINE_MAX);
            end
            default:
            begin
                line_we = 1'b0;
            end
        endcase
    end

    assign count_sat = (32'(tap_count) > KERNEL_MAX) ? CW'(KERNEL_MAX) : CW'(tap_count);
    assign weight_wr_addr = WA'(32'(position) * KERNEL_MAX + 32'(tap));
    assign weight_rd_addr = WA'(32'(pos_reg) * KERNEL_MAX + 32'(tap_reg));
    assign idx      = IDX_W'(base_reg) + IDX_W'(tap_reg);
    assign issue_en = cmd.issue && (tap_reg < cnt_reg);

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[LA'(position)] <= sample;
        end
        if (issue_en)
        begin
            smp_q_reg <= line_mem[LA'(idx)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (weight_we)
        begin
            weight_mem[weight_wr_addr] <= weight;
        end
        if (issue_en)
        begin
            wgt_q_reg <= weight_mem[weight_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bounds_we)
        begin
            bounds_mem[OA'(position)] <= {first_sample, count_sat};
        end
        if (cmd.accept)
        begin
            bounds_q_reg <= bounds_mem[OA'(position)];
        end
    end

    // Tap sequencing and pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            tap_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cnt_reg <= bounds_q_reg[CW-1:0];
                tap_reg <= '0;
            end
            else if (issue_en)
            begin
                tap_reg <= tap_reg + CW'(1);
            end
            s1_valid_reg <= issue_en;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pos_reg <= position;
        end
        if (cmd.load)
        begin
            base_reg <= bounds_q_reg[BND_W-1:CW];
        end
        s1_inrange_reg <= (32'(idx) < LINE_MAX);
        if (s1_inrange_reg)
        begin
            prod_reg <= $signed({1'b0, smp_q_reg}) * wgt_q_reg;
        end
        else
        begin
            prod_reg <= '0;
        end
        if (cmd.load)
        begin
            acc_reg <= ACC_INIT;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.emit)
        begin
            pixel_reg <= pixel_clip;
            index_reg <= pos_reg;
        end
    end

    // Shift out the fraction and clip to the pixel range.
    always_comb
    begin
        if (acc_reg[ACC_W-1])
        begin
            pixel_clip = '0;
        end
        else if (|acc_reg[ACC_W-2:PIX_HI])
        begin
            pixel_clip = flr_pkg::PIXEL_W'(flr_pkg::PIXEL_MAX);
        end
        else
        begin
            pixel_clip = acc_reg[PIX_HI-1:PIX_LO];
        end
    end

    always_comb
    begin
        sts.compute_req = (kind == flr_pkg::KIND_COMPUTE) && (32'(position) < OUT_MAX);
        sts.issue_done  = !(tap_reg < cnt_reg);
        sts.pipe_empty  = !s1_valid_reg && !s2_valid_reg;
    end

    assign pixel     = pixel_reg;
    assign out_index = index_reg;

endmodule

>>> hdl/fixed_point_line_resampler.sv
// Channel   Direction  Handshake           Fields
// request   in         start high, busy low kind position tap weight first_sample
//                                           tap_count sample
// result    out        done, one cycle     pixel out_index
//
// A table write or sample write is taken directly and busy stays low.
// A compute request keeps busy high until done rises, and the next request can
// be taken once busy is low; an empty kernel still runs the bounds lookup and
// the clip. The single multiply-accumulate lane, fed by one read port of the
// line store and of the weight table, sets these steps: the bounds lookup, one
// tap per cycle, the drain of the pipeline until it is seen empty, and the clip.
// Reset (rst_n, asynchronous, active low) clears the controller and the valid
// bits; the stores hold nothing defined until they are written.
// The receiver cannot stall: done lasts exactly one cycle; the result is held.
module fixed_point_line_resampler #(
    parameter int LINE_MAX   = 1024,
    parameter int OUT_MAX    = 1024,
    parameter int KERNEL_MAX = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [flr_pkg::KIND_W-1:0]          kind,
    input  logic [flr_pkg::POS_W-1:0]           position,
    input  logic [flr_pkg::TAP_W-1:0]           tap,
    input  logic signed [flr_pkg::WEIGHT_W-1:0] weight,
    input  logic [flr_pkg::FIRST_W-1:0]         first_sample,
    input  logic [flr_pkg::COUNT_W-1:0]         tap_count,
    input  logic [flr_pkg::SAMPLE_W-1:0]        sample,
    output logic                                done,
    output logic [flr_pkg::PIXEL_W-1:0]         pixel,
    output logic [flr_pkg::POS_W-1:0]           out_index
);

    // The controller sequences a compute request through the bounds lookup,
    // the tap loop and the final clip. The datapath holds all three stores
    // and performs writes directly in the cycle a request is taken.
    flr_pkg::flr_cmd_t cmd;
    flr_pkg::flr_sts_t sts;

    flr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // The datapath runs a three-stage pipeline per tap: memory read,
    // product, and accumulate. Taps that fall past the line end add zero.
    flr_datapath #(
        .LINE_MAX   (LINE_MAX),
        .OUT_MAX    (OUT_MAX),
        .KERNEL_MAX (KERNEL_MAX)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .kind         (kind),
        .position     (position),
        .tap          (tap),
        .weight       (weight),
        .first_sample (first_sample),
        .tap_count    (tap_count),
        .sample       (sample),
        .pixel        (pixel),
        .out_index    (out_index)
    );

`ifndef SYNTH
    // A result only follows a cycle in which the block was busy.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // A result strobe lasts exactly one cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held longer than one cycle");

    // The pixel is clipped only after the tap pipeline has drained.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(sts.pipe_empty))
        else $error("result issued while taps were still in flight");
`endif

endmodule
